@@ hw/rtl/bbd_pkg.sv @@
// Shared types, constants and lane-count functions for the bitmap box downscaler.
// No dependencies; imported by the top level, the checker and the testbench (not by the count RAM).
`timescale 1ns / 1ps

package bbd_pkg;

    localparam int MAX_ROW_BYTES = 256;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int ROW_BYTES_W   = 9;
    localparam int COUNT_W       = 12;
    localparam int PIX_W         = 8;
    localparam int SCALE_W       = 2;
    localparam int THR_W         = 6;
    localparam int BAND_W        = 3;
    localparam int FILL_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_MAX = ROW_BYTES_W'(MAX_ROW_BYTES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES       = 2'd0,
        CFG_SCALE_LOG2      = 2'd1,
        CFG_COUNT_THRESHOLD = 2'd2
    } t_cfg_index;

    // Request held between the read stage and the count/pack stage.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_byte;
        logic [COL_W-1:0] col;
        logic             band_zero;
        logic             last_col;
        logic             last_band;
        logic             image_start;
    } t_s2;

    typedef struct packed {
        logic [COUNT_W-1:0] fresh;
        logic [PIX_W-1:0]   bits;
    } t_lane_res;

    function automatic logic [3:0] popcount8(logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    // Add this byte's pixels to the packed per-lane block counts and
    // compare each wrapped lane count against the threshold.
    function automatic t_lane_res lane_update(logic [COUNT_W-1:0] old,
                                              logic [PIX_W-1:0]   pix,
                                              logic [SCALE_W-1:0] scale,
                                              logic [THR_W-1:0]   thr);
        t_lane_res  res;
        logic       c1;
        logic [2:0] c3;
        logic [4:0] c5;
        logic [6:0] c7;
        res = '0;
        case (scale)
            2'd0: begin
                for (int j = 0; j < 8; j++) begin
                    c1 = old[j] ^ pix[j];
                    res.fresh[j] = c1;
                    res.bits[j]  = 7'(c1) > 7'(thr);
                end
            end
            2'd1: begin
                for (int j = 0; j < 4; j++) begin
                    c3 = old[3*j +: 3] + 3'(popcount8({6'b0, pix[2*j +: 2]}));
                    res.fresh[3*j +: 3] = c3;
                    res.bits[j]         = 7'(c3) > 7'(thr);
                end
            end
            2'd2: begin
                for (int j = 0; j < 2; j++) begin
                    c5 = old[5*j +: 5] + 5'(popcount8({4'b0, pix[4*j +: 4]}));
                    res.fresh[5*j +: 5] = c5;
                    res.bits[j]         = 7'(c5) > 7'(thr);
                end
            end
            default: begin
                c7 = old[6:0] + 7'(popcount8(pix));
                res.fresh[6:0] = c7;
                res.bits[0]    = c7 > 7'(thr);
            end
        endcase
        return res;
    endfunction

endpackage

@@ hw/rtl/binary_bitmap_box_downscale.sv @@
// Stages: read stage, then count/pack stage, then a registered output request.
// Throughput: one pixel byte per cycle unless the output stalls; the count RAM does one read and one write
// per cycle, with a bypass when consecutive bytes hit the same column.
// Reset (synchronous, active low): counters, packer and valid flags clear; registers
// return to row_bytes=1, scale_log2=1, count_threshold=1. RAM content is not cleared.
`timescale 1ns / 1ps

module binary_bitmap_box_downscale
    import bbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_byte,
    input  logic                  i_image_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_out_byte,
    output logic                  o_row_last
);

    logic [ROW_BYTES_W-1:0] r_row_bytes;
    logic [SCALE_W-1:0]     r_scale_log2;
    logic [THR_W-1:0]       r_count_threshold;

    logic [COL_W-1:0]  r_column_index, n_column_index;
    logic [BAND_W-1:0] r_band_row, n_band_row;

    logic               r_s2_valid;
    t_s2                r_s2, n_s2;
    logic               r_fwd;
    logic [COUNT_W-1:0] r_fwd_data;

    logic [PIX_W-1:0]  r_pack_shift, n_pack_shift;
    logic [FILL_W-1:0] r_pack_fill, n_pack_fill;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_byte;
    logic             r_row_last;

    logic                   in_accept;
    logic                   s2_fire;
    logic                   emit;
    logic [COL_W-1:0]       col_cur;
    logic [BAND_W-1:0]      band_cur;
    logic [ROW_BYTES_W-1:0] eff_bytes;
    logic [FILL_W-1:0]      scale_n;
    logic [FILL_W-1:0]      lanes;
    logic [COUNT_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]     old_count;
    t_lane_res              lane_res;
    logic [PIX_W-1:0]       shift;
    logic [FILL_W-1:0]      fill;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes       <= ROW_BYTES_W'(1);
            r_scale_log2      <= SCALE_W'(1);
            r_count_threshold <= THR_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_BYTES:       r_row_bytes       <= i_cfg_data[ROW_BYTES_W-1:0];
                CFG_SCALE_LOG2:      r_scale_log2      <= i_cfg_data[SCALE_W-1:0];
                CFG_COUNT_THRESHOLD: r_count_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- read stage: position counters ----------------
    assign in_accept = i_in_valid && o_in_ready;
    assign scale_n   = FILL_W'(1) << r_scale_log2;

    always_comb begin
        col_cur  = i_image_start ? '0 : r_column_index;
        band_cur = i_image_start ? '0 : r_band_row;

        if (r_row_bytes == '0) begin
            eff_bytes = ROW_BYTES_W'(1);
        end else if (r_row_bytes > ROW_BYTES_MAX) begin
            eff_bytes = ROW_BYTES_MAX;
        end else begin
            eff_bytes = r_row_bytes;
        end

        n_s2.pixel_byte  = i_pixel_byte;
        n_s2.col         = col_cur;
        n_s2.band_zero   = (band_cur == '0);
        n_s2.last_col    = (ROW_BYTES_W'(col_cur) + ROW_BYTES_W'(1)) >= eff_bytes;
        n_s2.last_band   = (FILL_W'(band_cur) + FILL_W'(1)) >= scale_n;
        n_s2.image_start = i_image_start;

        if (n_s2.last_col) begin
            n_column_index = '0;
            n_band_row     = n_s2.last_band ? '0 : band_cur + BAND_W'(1);
        end else begin
            n_column_index = col_cur + COL_W'(1);
            n_band_row     = band_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_index <= '0;
            r_band_row     <= '0;
            r_s2_valid     <= 1'b0;
            r_fwd          <= 1'b0;
        end else begin
            if (in_accept) begin
                r_column_index <= n_column_index;
                r_band_row     <= n_band_row;
                // bypass the count being written in this same cycle
                r_fwd          <= s2_fire && (r_s2.col == col_cur);
            end
            if (in_accept) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s2       <= n_s2;
            r_fwd_data <= lane_res.fresh;
        end
    end

    bbd_count_ram #(
        .DEPTH  (MAX_ROW_BYTES),
        .DATA_W (COUNT_W)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (s2_fire),
        .i_waddr (r_s2.col),
        .i_wdata (lane_res.fresh),
        .i_re    (in_accept),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    // ---------------- count / pack stage ----------------
    assign lanes = FILL_W'(8) >> r_scale_log2;

    always_comb begin
        if (r_s2.band_zero) begin
            old_count = '0;
        end else if (r_fwd) begin
            old_count = r_fwd_data;
        end else begin
            old_count = ram_rdata;
        end
        lane_res = lane_update(old_count, r_s2.pixel_byte, r_scale_log2, r_count_threshold);

        shift = r_s2.image_start ? '0 : r_pack_shift;
        fill  = r_s2.image_start ? '0 : r_pack_fill;
        if (r_s2.last_band) begin
            for (int j = 0; j < 8; j++) begin
                if ((FILL_W'(j) < lanes) && !fill[FILL_W-1]) begin
                    shift[fill[2:0]] = lane_res.bits[j];
                    fill             = fill + FILL_W'(1);
                end
            end
        end

        emit = r_s2.last_band && (fill[FILL_W-1] || (r_s2.last_col && (fill != '0)));
        n_pack_shift = emit ? '0 : shift;
        n_pack_fill  = emit ? '0 : fill;
    end

    assign s2_fire    = r_s2_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s2_valid || s2_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_shift <= '0;
            r_pack_fill  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s2_fire) begin
                r_pack_shift <= n_pack_shift;
                r_pack_fill  <= n_pack_fill;
            end
            if (s2_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && emit) begin
            r_out_byte <= shift;
            r_row_last <= r_s2.last_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_row_last  = r_row_last;

endmodule

@@ hw/rtl/bbd_count_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
// Generic; holds the per-column partial block counts.
`timescale 1ns / 1ps

module bbd_count_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 12,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bbd_checker.sv @@
// Port-level checks for the bitmap box downscaler, bound to the top level.
// Depends on bbd_pkg for port widths.
`timescale 1ns / 1ps

module bbd_checker
    import bbd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [PIX_W-1:0]      i_pixel_byte,
    input logic                  i_image_start,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PIX_W-1:0]      o_out_byte,
    input logic                  o_row_last
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output request survived reset");

    // stalled output request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_row_last))
        else $error("stalled output request changed");

    // with the output register empty, the pipeline can always take a byte
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind binary_bitmap_box_downscale bbd_checker u_bbd_checker (.*);

@@ tb/testbench.sv @@
// Self-checking bench for binary_bitmap_box_downscale: raster bytes in, shrunk bitmap bytes out.
// Depends on bbd_pkg and the block RTL; runs its own shrink predictor with random stalls.
`timescale 1ns / 1ps

module testbench;
    import bbd_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 4;

    typedef struct {
        logic [PIX_W-1:0] pixels;
        logic             start;
    } t_raster_byte;

    typedef struct {
        logic [PIX_W-1:0] bits;
        logic             row_end;
    } t_shrunk_byte;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROW_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [PIX_W-1:0]      pixel_byte = '0;
    logic                  image_start = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_out_byte;
    logic                  o_row_last;

    // Predictor state and its copy of the registers
    logic [ROW_BYTES_W-1:0] cfg_row_bytes = 9'd1;
    logic [SCALE_W-1:0]     cfg_scale = 2'd1;
    logic [THR_W-1:0]       cfg_threshold = 6'd1;
    logic [COUNT_W-1:0]     col_counts [MAX_ROW_BYTES];
    logic [COL_W-1:0]       cur_col = '0;
    logic [BAND_W-1:0]      cur_band = '0;
    logic [PIX_W-1:0]       pack_bits = '0;
    logic [FILL_W-1:0]      pack_count = '0;

    t_raster_byte raster_q [$];
    t_shrunk_byte shrunk_q [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  out_seen = 0;
    int  in_gap = 0;
    int  out_wait = 0;
    bit  in_burst = 1'b0;
    bit  out_burst = 1'b0;

    binary_bitmap_box_downscale dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_byte  (pixel_byte),
        .i_image_start (image_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (o_out_byte),
        .o_row_last    (o_row_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int row_span();
        if (cfg_row_bytes == 0) return 1;
        if (cfg_row_bytes > MAX_ROW_BYTES) return MAX_ROW_BYTES;
        return int'(cfg_row_bytes);
    endfunction

    // Fold one raster byte into the per-column block counts and queue any finished byte.
    task automatic shrink_step(input logic [PIX_W-1:0] pix, input logic start);
        int                 span, sc, lanes, lb, lmask, col, lane;
        logic [COUNT_W-1:0] old_cnt, new_cnt;
        bit                 last_col, last_band;
        t_shrunk_byte       res;
        span  = row_span();
        sc    = 1 << cfg_scale;
        lanes = 8 >> cfg_scale;
        lb    = 2 * cfg_scale + 1;
        lmask = (1 << lb) - 1;
        if (start) begin
            cur_col    = '0;
            cur_band   = '0;
            pack_bits  = '0;
            pack_count = '0;
        end
        col       = int'(cur_col);
        old_cnt   = (cur_band == 0) ? '0 : col_counts[col];
        last_col  = (col + 1 >= span);
        last_band = (int'(cur_band) + 1 >= sc);
        new_cnt   = '0;
        for (int j = 0; j < lanes; j++) begin
            lane = (int'(old_cnt) >> (j * lb)) & lmask;
            lane = (lane + $countones((int'(pix) >> (j * sc)) & ((1 << sc) - 1))) & lmask;
            new_cnt |= COUNT_W'(lane << (j * lb));
            // drop pixels past a full byte
            if (last_band && pack_count < 8) begin
                pack_bits[pack_count] = (lane > int'(cfg_threshold));
                pack_count++;
            end
        end
        col_counts[col] = new_cnt;
        if (last_band && (pack_count >= 8 || (last_col && pack_count > 0))) begin
            res.bits    = pack_bits;
            res.row_end = last_col;
            shrunk_q.push_back(res);
            pack_bits  = '0;
            pack_count = '0;
        end
        if (last_col) begin
            cur_col  = '0;
            cur_band = last_band ? '0 : cur_band + 1'b1;
        end else begin
            cur_col = COL_W'(col + 1);
        end
    endtask

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Input side: present queued bytes, idling for a random gap between requests.
    always @(posedge i_clk) begin : raster_drive
        logic next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            next_valid = in_valid;
            if (in_valid && o_in_ready) begin
                shrink_step(pixel_byte, image_start);
                void'(raster_q.pop_front());
                if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, 5);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (raster_q.size() != 0) begin
                    next_valid = 1'b1;
                    pixel_byte  <= raster_q[0].pixels;
                    image_start <= raster_q[0].start;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Output side: check each request against the oldest predicted byte, then stall at random.
    always @(posedge i_clk) begin : shrunk_check
        logic         next_ready;
        t_shrunk_byte want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_wait = 0;
        end else begin
            next_ready = out_ready;
            if (o_out_valid && out_ready) begin
                if (shrunk_q.size() == 0) begin
                    flag_error($sformatf("output %0d: none expected, got byte %02h row_last %0b",
                                         out_seen, o_out_byte, o_row_last));
                end else begin
                    want = shrunk_q.pop_front();
                    if (o_out_byte !== want.bits)
                        flag_error($sformatf("output %0d: byte expected %02h got %02h",
                                             out_seen, want.bits, o_out_byte));
                    if (o_row_last !== want.row_end)
                        flag_error($sformatf("output %0d: row_last expected %0b got %0b",
                                             out_seen, want.row_end, o_row_last));
                end
                out_seen++;
                if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 5);
                next_ready = 1'b0;
            end
            if (!next_ready) begin
                if (out_wait > 0) out_wait--;
                else next_ready = 1'b1;
            end
            out_ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_byte(input logic [PIX_W-1:0] pix, input logic start);
        t_raster_byte b;
        b.pixels = pix;
        b.start  = start;
        raster_q.push_back(b);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_BYTES:       cfg_row_bytes = val;
            CFG_SCALE_LOG2:      cfg_scale = SCALE_W'(val);
            CFG_COUNT_THRESHOLD: cfg_threshold = THR_W'(val);
            default:             ;
        endcase
        @(negedge i_clk);
    endtask

    // Hold until every request is consumed and every byte is back, then let the pipe settle.
    task automatic wait_drained();
        do @(negedge i_clk); while (raster_q.size() != 0 || in_valid || shrunk_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] draw_pixels(input int mode);
        case (mode)
            0:       return PIX_W'($urandom);
            1:       return PIX_W'($urandom & $urandom & $urandom);
            2:       return PIX_W'($urandom | $urandom | $urandom);
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Queue one image of whole bands, sometimes cut short inside a band or a row.
    task automatic queue_image(output int pushed);
        int span, sc, bands, rows, tail, mode, i;
        span  = row_span();
        sc    = 1 << cfg_scale;
        bands = (sc * span >= 96) ? 1 : $urandom_range(1, 96 / (sc * span));
        rows  = bands * sc;
        if (sc > 1 && $urandom_range(0, 3) == 0) rows += $urandom_range(1, sc - 1);
        tail  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) - 1 : 0;
        mode  = $urandom_range(0, 3);
        pushed = rows * span + tail;
        for (i = 0; i < pushed; i++) push_byte(draw_pixels(mode), i == 0);
    endtask

    initial begin : stimulus
        int total, pushed, phase, scale, row_len, thr, images;
        total = 0;
        phase = 0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at their reset values
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h81, 1'b0);
        wait_drained();

        // zero row length acts as one byte; full scale, threshold floor
        write_reg(CFG_ROW_BYTES, 9'd0);
        write_reg(CFG_SCALE_LOG2, 9'd0);
        write_reg(CFG_COUNT_THRESHOLD, 9'd0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b0);
        wait_drained();

        // run to the last band row at scale 4, then drop to scale 1 mid-row: packer overflows
        write_reg(CFG_ROW_BYTES, 9'd2);
        write_reg(CFG_SCALE_LOG2, 9'd2);
        write_reg(CFG_COUNT_THRESHOLD, 9'd63);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_drained();
        write_reg(CFG_COUNT_THRESHOLD, 9'd0);
        write_reg(CFG_SCALE_LOG2, 9'd0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h01, 1'b0);
        wait_drained();

        // shorten the row while the column is already past the new end
        write_reg(CFG_ROW_BYTES, 9'd3);
        push_byte(8'h80, 1'b1);
        push_byte(8'h7F, 1'b0);
        wait_drained();
        write_reg(CFG_ROW_BYTES, 9'd1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h18, 1'b0);
        wait_drained();

        while (total < RANDOM_ITEMS) begin
            phase++;
            scale = (phase <= 4) ? 4 - phase : $urandom_range(0, 3);
            case ($urandom_range(0, 15))
                0:       row_len = 0;
                1, 2:    row_len = $urandom_range(9, 40);
                default: row_len = $urandom_range(1, 8);
            endcase
            // one pass with a row at or past the store size
            if (phase == 5) begin
                row_len = $urandom_range(256, 511);
                scale   = 0;
            end
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 63;
                default: thr = $urandom_range(0, (1 << scale) * (1 << scale));
            endcase
            write_reg(CFG_ROW_BYTES, CFG_DATA_W'(row_len));
            write_reg(CFG_SCALE_LOG2, CFG_DATA_W'(scale));
            write_reg(CFG_COUNT_THRESHOLD, CFG_DATA_W'(thr));
            images = (phase == 5) ? 1 : $urandom_range(1, 3);
            repeat (images) begin
                queue_image(pushed);
                total += pushed;
            end
            wait_drained();
        end

        repeat (4 * SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && shrunk_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
